// File: hdl/integer_matrix_vector_mac_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the matrix-vector MAC checker.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_VECTOR_MAC_CORE_DEFINES_SVH
`define INTEGER_MATRIX_VECTOR_MAC_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define IMVM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define IMVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/imvm_pkg.sv
// ----------------------------------------------------------------------------
// imvm_pkg
// Types, codes and helpers shared by the matrix-vector MAC files.
// ----------------------------------------------------------------------------
package imvm_pkg;

  localparam int IMVM_MAX_DIM_DEFAULT = 16;
  localparam logic [4:0] DIM_RESET = 5'd16;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tok_flags_t;

  typedef struct packed {
    logic wr;
    logic add;
  } mem_ctl_t;

  function automatic logic [4:0] clamp_dim(logic [4:0] v, int max_dim);
    logic [4:0] r;
    r = v;
    if (v == 5'd0) begin
      r = 5'd1;
    end else if (int'(v) > max_dim) begin
      r = 5'(max_dim);
    end
    return r;
  endfunction

endpackage

// File: hdl/imvm_cell.sv
// ----------------------------------------------------------------------------
// imvm_cell
// One matrix row: row storage, multiplier and accumulator; passes the
// vector token to its neighbor every cycle.
// ----------------------------------------------------------------------------
module imvm_cell import imvm_pkg::*; #(
  parameter int MAX_DIM = IMVM_MAX_DIM_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mem_ctl_t                   ctl,
  input  logic [$clog2(MAX_DIM)-1:0] cmd_addr,
  input  logic [31:0]                cmd_data,
  input  tok_flags_t                 tok_flags_in,
  input  logic [$clog2(MAX_DIM)-1:0] tok_col_in,
  input  logic [31:0]                tok_value_in,
  output tok_flags_t                 tok_flags_out,
  output logic [$clog2(MAX_DIM)-1:0] tok_col_out,
  output logic [31:0]                tok_value_out,
  output logic                       done,
  output logic [31:0]                acc
);

  localparam int AW = $clog2(MAX_DIM);

  logic [31:0]   mem [MAX_DIM];
  logic [31:0]   rdata;
  logic [AW-1:0] rd_addr;
  tok_flags_t    tok_flags_q;
  logic [AW-1:0] tok_col_q;
  logic [31:0]   tok_value_q;
  tok_flags_t    prod_flags;
  logic [31:0]   prod;

  assign rd_addr = tok_flags_in.valid ? tok_col_in : cmd_addr;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[cmd_addr] <= ctl.add ? rdata + cmd_data : cmd_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    tok_col_q   <= tok_col_in;
    tok_value_q <= tok_value_in;
    prod        <= 32'(rdata * tok_value_q);
    if (prod_flags.valid) begin
      acc <= prod_flags.first ? prod : acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_flags_q <= '0;
      prod_flags  <= '0;
      done        <= 1'b0;
    end else begin
      tok_flags_q <= tok_flags_in;
      prod_flags  <= tok_flags_q;
      done        <= prod_flags.valid && prod_flags.last;
    end
  end

  assign tok_flags_out = tok_flags_q;
  assign tok_col_out   = tok_col_q;
  assign tok_value_out = tok_value_q;

endmodule

// File: hdl/integer_matrix_vector_mac_core.sv
// ----------------------------------------------------------------------------
// integer_matrix_vector_mac_core
// Signed integer matrix-vector multiply over a row of MAC cells, one per row.
// ----------------------------------------------------------------------------
// Channel   Signals                                  Transaction
// input     start/busy, action row col value last    start && !busy
// result    result_strobe, row_index dot_value last_row  result_strobe
// config    APB psel penable pwrite paddr pwdata     psel&penable&pwrite
//
// Write and load without last leave busy low. An in-range add reads, then
// writes back through the cell port in ST_ADD. Load with last feeds the
// vector in ST_PROD, then waits in ST_DRAIN; rows appear in order, one row a
// cycle, set by the vector token passing one cell per cycle along the row of
// cells. After reset, a clearing pass over every address holds busy high.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module integer_matrix_vector_mac_core import imvm_pkg::*; #(
  parameter int MAX_DIM = IMVM_MAX_DIM_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic signed [31:0] value,
  input  logic               last,
  output logic               result_strobe,
  output logic [3:0]         row_index,
  output logic signed [31:0] dot_value,
  output logic               last_row,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_DIM);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_PROD  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  state_t        state;
  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] feed_cnt;
  logic [3:0]    row_q;
  logic [AW-1:0] col_q;
  logic [31:0]   value_q;
  logic [4:0]    num_rows;
  logic [4:0]    num_cols;

  logic          accept;
  logic          in_range;
  logic          col_ok;
  logic          cfg_wr;

  mem_ctl_t      ctl [MAX_DIM];
  logic [AW-1:0] cmd_addr;
  logic [31:0]   cmd_data;

  logic [31:0]   vmem [MAX_DIM];
  logic          vwr;
  logic [AW-1:0] vwaddr;
  logic [31:0]   vwdata;
  logic [31:0]   vrdata;
  tok_flags_t    tok0_flags;
  logic [AW-1:0] tok0_col;

  tok_flags_t    tf [MAX_DIM+1];
  tok_flags_t    tf_out [MAX_DIM];
  logic [AW-1:0] tc [MAX_DIM+1];
  logic [31:0]   tv [MAX_DIM+1];
  logic          cell_done [MAX_DIM];
  logic [31:0]   cell_acc [MAX_DIM];

  logic          sel_hit;
  logic [3:0]    sel_row;
  logic [31:0]   sel_acc;
  logic          sel_last;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign col_ok   = ({1'b0, col} < num_cols);
  assign in_range = ({1'b0, row} < num_rows) && col_ok;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = {27'b0, (paddr[2] == REG_NUM_COLS) ? num_cols : num_rows};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= clamp_dim(DIM_RESET, MAX_DIM);
      num_cols <= clamp_dim(DIM_RESET, MAX_DIM);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NUM_ROWS) begin
        num_rows <= clamp_dim(pwdata[4:0], MAX_DIM);
      end else begin
        num_cols <= clamp_dim(pwdata[4:0], MAX_DIM);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      feed_cnt   <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(MAX_DIM - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (action == ACT_ADD && in_range) begin
              state <= ST_ADD;
            end else if (action == ACT_LOAD && last) begin
              state    <= ST_PROD;
              feed_cnt <= '0;
            end
          end
        end
        ST_ADD: begin
          state <= ST_IDLE;
        end
        ST_PROD: begin
          feed_cnt <= feed_cnt + 1'b1;
          if (int'(feed_cnt) + 1 == int'(num_cols)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (result_strobe && last_row) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok0_flags <= '0;
    end else begin
      tok0_flags.valid <= (state == ST_PROD);
      tok0_flags.first <= (state == ST_PROD) && (feed_cnt == '0);
      tok0_flags.last  <= (state == ST_PROD) && (int'(feed_cnt) + 1 == int'(num_cols));
    end
  end

  always_ff @(posedge clk) begin
    tok0_col <= feed_cnt;
    if (accept) begin
      row_q   <= row;
      col_q   <= AW'(col);
      value_q <= value;
    end
  end

  always_comb begin
    cmd_addr = AW'(col);
    cmd_data = value;
    vwr      = 1'b0;
    vwaddr   = AW'(col);
    vwdata   = value;
    for (int r = 0; r < MAX_DIM; r++) begin
      ctl[r] = '0;
    end
    unique case (state)
      ST_CLEAR: begin
        cmd_addr = clr_cnt;
        cmd_data = '0;
        vwr      = 1'b1;
        vwaddr   = clr_cnt;
        vwdata   = '0;
        for (int r = 0; r < MAX_DIM; r++) begin
          ctl[r].wr = 1'b1;
        end
      end
      ST_IDLE: begin
        vwr = accept && (action == ACT_LOAD) && col_ok;
        for (int r = 0; r < MAX_DIM; r++) begin
          ctl[r].wr = accept && (action == ACT_WRITE) && in_range && (int'(row) == r);
        end
      end
      ST_ADD: begin
        cmd_addr = col_q;
        cmd_data = value_q;
        for (int r = 0; r < MAX_DIM; r++) begin
          ctl[r].wr  = (int'(row_q) == r);
          ctl[r].add = 1'b1;
        end
      end
      ST_PROD, ST_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwr) begin
      vmem[vwaddr] <= vwdata;
    end
    vrdata <= vmem[feed_cnt];
  end

  assign tf[0] = tok0_flags;
  assign tc[0] = tok0_col;
  assign tv[0] = vrdata;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    imvm_cell #(
      .MAX_DIM(MAX_DIM)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl[g]),
      .cmd_addr     (cmd_addr),
      .cmd_data     (cmd_data),
      .tok_flags_in (tf[g]),
      .tok_col_in   (tc[g]),
      .tok_value_in (tv[g]),
      .tok_flags_out(tf_out[g]),
      .tok_col_out  (tc[g+1]),
      .tok_value_out(tv[g+1]),
      .done         (cell_done[g]),
      .acc          (cell_acc[g])
    );

    // drop the token past the last row in use
    assign tf[g+1] = (g + 1 < int'(num_rows)) ? tf_out[g] : '0;
  end

  always_comb begin
    sel_hit  = 1'b0;
    sel_row  = '0;
    sel_acc  = '0;
    sel_last = 1'b0;
    for (int r = 0; r < MAX_DIM; r++) begin
      if (cell_done[r] && (r < int'(num_rows))) begin
        sel_hit  = 1'b1;
        sel_row  = sel_row | 4'(r);
        sel_acc  = sel_acc | cell_acc[r];
        sel_last = sel_last | (r + 1 == int'(num_rows));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
      last_row      <= 1'b0;
    end else begin
      result_strobe <= sel_hit;
      last_row      <= sel_hit && sel_last;
    end
  end

  always_ff @(posedge clk) begin
    row_index <= sel_row;
    dot_value <= sel_acc;
  end

endmodule

// File: hdl/imvm_checker.sv
// ----------------------------------------------------------------------------
// imvm_checker
// Port-level checks on the matrix-vector MAC: product sequencing and busy.
// ----------------------------------------------------------------------------
`include "integer_matrix_vector_mac_core_defines.svh"

module imvm_checker import imvm_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] action,
  input logic       last,
  input logic       result_strobe,
  input logic [3:0] row_index,
  input logic       last_row
);

  `IMVM_ASSERT_NEXT(a_load_last_busy, start && !busy && action == ACT_LOAD && last, busy, "product start did not raise busy")
  `IMVM_ASSERT_NEXT(a_write_no_busy, start && !busy && action == ACT_WRITE, !busy, "element write raised busy")
  `IMVM_ASSERT_SAME(a_strobe_busy, result_strobe, busy, "result shown while idle")
  `IMVM_ASSERT_NEXT(a_rows_in_order, result_strobe && !last_row, result_strobe && row_index == 4'($past(row_index) + 4'd1), "result rows not consecutive")
  `IMVM_ASSERT_NEXT(a_last_row_ends, result_strobe && last_row, !result_strobe && !busy, "product did not end after last row")

endmodule

bind integer_matrix_vector_mac_core imvm_checker u_imvm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .last         (last),
  .result_strobe(result_strobe),
  .row_index    (row_index),
  .last_row     (last_row)
);

// File: bench/integer_matrix_vector_mac_core_tb.sv
// ----------------------------------------------------------------------------
// integer_matrix_vector_mac_core_tb
// Self-checking bench for the matrix-vector MAC core. Element writes, adds and
// vector loads go in over start/busy, and the sizes are set over APB between
// phases. A scoreboard keeps its own matrix, vector and sizes, and computes the
// row dot products of every product. It checks each strobed result against
// the oldest expected row. A directed burst covers value extremes, wrapping
// adds, out-of-range elements and indexes, the unused action, and last on
// non-load items. Random phases follow, mostly full vector loads with random
// content and some noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_matrix_vector_mac_core_tb;
  import imvm_pkg::*;

  localparam int DIM = IMVM_MAX_DIM_DEFAULT;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int QUIET_CYCLES = 2 * DIM + 8;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_TARGET = 450;
  localparam int NUM_PHASES = 10;

  typedef struct {
    logic [3:0]  row_idx;
    logic [31:0] dot;
    logic        last_row;
  } row_result_t;

  class dot_product_board;
    logic [31:0] matrix [DIM*DIM];
    logic [31:0] vector [DIM];
    int unsigned rows_used;
    int unsigned cols_used;
    row_result_t expected_rows[$];
    int unsigned errors;

    function new();
      foreach (matrix[i]) matrix[i] = '0;
      foreach (vector[i]) vector[i] = '0;
      rows_used = DIM;
      cols_used = DIM;
      errors = 0;
    endfunction

    function void note_config(logic reg_sel, logic [31:0] data);
      int unsigned dim;
      dim = data[4:0];
      if (dim == 0) dim = 1;
      if (dim > DIM) dim = DIM;
      if (reg_sel == REG_NUM_ROWS) rows_used = dim;
      else cols_used = dim;
    endfunction

    function void note_input(logic [1:0] act, logic [3:0] r, logic [3:0] c,
                             logic [31:0] v, logic lst);
      logic [31:0] acc;
      row_result_t res;
      if (act == ACT_WRITE || act == ACT_ADD) begin
        if (r < rows_used && c < cols_used) begin
          if (act == ACT_WRITE) matrix[r*DIM+c] = v;
          else matrix[r*DIM+c] = matrix[r*DIM+c] + v;
        end
      end else if (act == ACT_LOAD) begin
        if (c < cols_used) vector[c] = v;
        if (lst) begin
          for (int i = 0; i < rows_used; i++) begin
            acc = '0;
            for (int j = 0; j < cols_used; j++) acc = acc + matrix[i*DIM+j] * vector[j];
            res.row_idx = 4'(i);
            res.dot = acc;
            res.last_row = (i + 1 == rows_used);
            expected_rows.push_back(res);
          end
        end
      end
    endfunction

    function void check_result(logic [3:0] r, logic [31:0] d, logic lr);
      row_result_t exp_row;
      if (expected_rows.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result row %0d dot %h last %b", $realtime, r, d, lr);
      end else begin
        exp_row = expected_rows.pop_front();
        if (exp_row.row_idx !== r || exp_row.dot !== d || exp_row.last_row !== lr) begin
          errors++;
          if (errors <= 10)
            $display("%0t: mismatch expected row %0d dot %h last %b, got row %0d dot %h last %b",
                     $realtime, exp_row.row_idx, exp_row.dot, exp_row.last_row, r, d, lr);
        end
      end
    endfunction

    function void drain_check();
      while (expected_rows.size() != 0) begin
        void'(expected_rows.pop_front());
        errors++;
        if (errors <= 10) $display("%0t: expected result never arrived", $realtime);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         action;
  logic [3:0]         row;
  logic [3:0]         col;
  logic signed [31:0] value;
  logic               last;
  logic               result_strobe;
  logic [3:0]         row_index;
  logic signed [31:0] dot_value;
  logic               last_row;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  dot_product_board sb;
  int n_items;
  bit idle_en;
  int stall_cnt;

  integer_matrix_vector_mac_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .row(row), .col(col), .value(value), .last(last),
    .result_strobe(result_strobe), .row_index(row_index), .dot_value(dot_value),
    .last_row(last_row),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_result(row_index, dot_value, last_row);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (psel && penable)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      4, 5: return 32'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(logic [1:0] act, logic [3:0] r, logic [3:0] c,
                           logic [31:0] v, logic lst);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    action = act;
    row = r;
    col = c;
    value = v;
    last = lst;
    do @(posedge clk); while (busy);
    sb.note_input(act, r, c, v, lst);
    n_items++;
  endtask

  task automatic cfg_write(logic reg_sel, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_sel, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.note_config(reg_sel, data);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // drop start, drain outstanding rows, then let in-flight adds finish
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic full_vector_seq();
    int nw;
    nw = $urandom_range(1, 8);
    repeat (nw)
      send_item(($urandom_range(0, 3) == 0) ? ACT_ADD : ACT_WRITE,
                4'($urandom_range(0, sb.rows_used - 1)),
                4'($urandom_range(0, sb.cols_used - 1)),
                rand_value(), 1'($urandom_range(0, 1)));
    for (int c = 0; c < sb.cols_used; c++)
      send_item(ACT_LOAD, 4'($urandom()), 4'(c), rand_value(), c == sb.cols_used - 1);
  endtask

  task automatic run_phase(int target);
    int base;
    int n;
    base = n_items;
    while (n_items - base < target) begin
      if (n_items < ITEM_TARGET - 60) idle_en = ($urandom_range(0, 3) != 0);
      else idle_en = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: full_vector_seq();
        6, 7: send_item(2'($urandom()), 4'($urandom()), 4'($urandom()), rand_value(),
                        1'($urandom_range(0, 1)));
        8: begin
          n = $urandom_range(1, sb.cols_used);
          repeat (n)
            send_item(ACT_LOAD, 4'($urandom()), 4'($urandom()), rand_value(),
                      $urandom_range(0, 3) == 0);
        end
        default: begin
          n = $urandom_range(2, 6);
          repeat (n)
            send_item(ACT_ADD, 4'($urandom_range(0, sb.rows_used - 1)),
                      4'($urandom_range(0, sb.cols_used - 1)), rand_value(), 1'b0);
        end
      endcase
    end
  endtask

  initial begin
    int cfg_rows [7];
    int cfg_cols [7];
    logic [31:0] rows_word;
    logic [31:0] cols_word;
    cfg_rows = '{16, 1, 16, 1, 0, 31, 20};
    cfg_cols = '{16, 1, 1, 16, 0, 17, 0};
    sb = new();
    n_items = 0;
    idle_en = 1'b0;
    stall_cnt = 0;
    rst = 1'b1;
    start = 1'b0;
    action = ACT_WRITE;
    row = '0;
    col = '0;
    value = '0;
    last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    do @(posedge clk); while (busy);

    cfg_write(REG_NUM_ROWS, 32'd3);
    cfg_write(REG_NUM_COLS, 32'd4);
    send_item(ACT_WRITE, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b0);
    send_item(ACT_WRITE, 4'd0, 4'd1, 32'h8000_0000, 1'b0);
    send_item(ACT_WRITE, 4'd2, 4'd3, 32'hFFFF_FFFF, 1'b0);
    send_item(ACT_ADD,   4'd2, 4'd3, 32'h8000_0000, 1'b0);
    send_item(ACT_ADD,   4'd1, 4'd2, 32'd5, 1'b0);
    send_item(ACT_ADD,   4'd1, 4'd2, 32'h7FFF_FFFF, 1'b0);
    send_item(ACT_WRITE, 4'd3, 4'd0, 32'd99, 1'b0);
    send_item(ACT_WRITE, 4'd0, 4'd4, 32'd99, 1'b0);
    send_item(ACT_ADD,   4'd15, 4'd15, 32'd99, 1'b0);
    send_item(ACT_WRITE, 4'd1, 4'd0, 32'd7, 1'b1);
    send_item(ACT_ADD,   4'd1, 4'd1, 32'hFFFF_FFF0, 1'b1);
    send_item(ACT_NONE,  4'd0, 4'd0, 32'd123, 1'b1);
    send_item(ACT_LOAD,  4'd0, 4'd0, 32'h7FFF_FFFF, 1'b0);
    send_item(ACT_LOAD,  4'd15, 4'd1, 32'h8000_0000, 1'b0);
    send_item(ACT_LOAD,  4'd0, 4'd2, 32'd3, 1'b0);
    send_item(ACT_LOAD,  4'd0, 4'd15, 32'd5, 1'b0);
    send_item(ACT_LOAD,  4'd0, 4'd3, 32'hFFFF_FFFF, 1'b1);
    send_item(ACT_LOAD,  4'd0, 4'd9, 32'd42, 1'b1);
    send_item(ACT_WRITE, 4'd2, 4'd0, 32'hFFFF_FFFF, 1'b0);
    send_item(ACT_LOAD,  4'd0, 4'd0, 32'd2, 1'b1);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 7) begin
        rows_word = 32'(cfg_rows[p]);
        cols_word = 32'(cfg_cols[p]);
      end else begin
        rows_word = {27'($urandom() >> 5), 5'($urandom_range(0, 31))};
        cols_word = {27'($urandom() >> 5), 5'($urandom_range(0, 31))};
      end
      cfg_write(REG_NUM_ROWS, rows_word);
      cfg_write(REG_NUM_COLS, cols_word);
      run_phase((ITEM_TARGET - n_items) / (NUM_PHASES - p));
      settle();
    end

    sb.drain_check();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
